>>> hw/rtl/fts_pkg.sv
// Shared types and constants for the frame time statistics core.
package fts_pkg;
	localparam int unsigned TopDepthDefault = 16;
	localparam int unsigned DataW = 32;
	localparam int unsigned RankW = 4;
	localparam logic OpCollect = 1'b0;
	localparam logic OpClear = 1'b1;

	typedef logic [DataW-1:0] data_t;

	// Command broadcast from the sequencer to every top-list cell.
	typedef struct packed {
		logic clear;   // zero the cell
		logic load;    // take the carry from the left neighbor
		logic shift;   // rotate values one step toward rank 0 for readout
	} cell_ctrl_t;
endpackage

>>> hw/rtl/fts_divider.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
module fts_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [32:0]   dividend,
	input  fts_pkg::data_t       divisor,
	output logic                 done,
	output logic signed [32:0]   quotient
);
	import fts_pkg::*;

	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;

	assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd32;
				neg_q <= dividend[32];
				quo_q <= dividend[32] ? 32'(-dividend) : dividend[31:0];
				dvs_q <= divisor;
				rem_q <= '0;
			end else if (busy_q) begin
				if (!trial[32]) begin
					rem_q <= trial[31:0];
					quo_q <= {quo_q[30:0], 1'b1};
				end else begin
					rem_q <= {rem_q[30:0], quo_q[31]};
					quo_q <= {quo_q[30:0], 1'b0};
				end
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign quotient = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
endmodule

>>> hw/rtl/fts_top_cell.sv
// One rank of the descending top list: compare, keep the larger, pass the smaller.
module fts_top_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  fts_pkg::cell_ctrl_t ctrl,
	input  logic                active,
	input  fts_pkg::data_t      carry_in,
	output fts_pkg::data_t      carry_out,
	input  fts_pkg::data_t      rot_in,
	output fts_pkg::data_t      value
);
	import fts_pkg::*;

	data_t val_q;
	data_t carry_q;

	assign value = val_q;
	assign carry_out = carry_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
			carry_q <= '0;
		end else if (ctrl.clear) begin
			val_q <= '0;
			carry_q <= '0;
		end else if (ctrl.shift) begin
			val_q <= rot_in;
		end else if (ctrl.load) begin
			if (active && carry_in > val_q) begin
				val_q <= carry_in;
				carry_q <= val_q;
			end else begin
				carry_q <= carry_in;
			end
		end
	end
endmodule

>>> hw/rtl/frame_time_statistics_core.sv
// Top level of the frame time statistics core: sequencer, divider and top-list cells.
//
// Channel  Direction  Handshake       Payload
// in       input      in_valid/stall  operation, sample_ms, in_critical_frame,
//                                     critical_frame_count
// out      output     out_valid/stall sample_count .. critical_mean_ms, rank,
//                                     top_value_ms, last
// cfg      input      valid/ready     budget
//
// A collect transaction after the first runs the shared bit-serial divider twice
// (mean, deviation), and a third time for the critical mean only when the sample
// is over budget in a critical frame with a nonzero frame count. Then the carry
// ripples down the cell row, one rank per cycle, and TOP_DEPTH output transactions
// follow, one per cycle when out_stall is low. A clear or a first sample goes
// straight to output. The row rotates one rank per output transaction.
// Reset clears all statistics and the budget.
// One item is worked on at a time; in_stall is high until its last result leaves.
module frame_time_statistics_core #(
	parameter int unsigned TOP_DEPTH = fts_pkg::TopDepthDefault
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     operation,
	input  fts_pkg::data_t           sample_ms,
	input  logic                     in_critical_frame,
	input  fts_pkg::data_t           critical_frame_count,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  fts_pkg::data_t           budget,
	output logic                     out_valid,
	input  logic                     out_stall,
	output fts_pkg::data_t           sample_count,
	output fts_pkg::data_t           mean_ms,
	output fts_pkg::data_t           deviation_ms,
	output fts_pkg::data_t           max_ms,
	output fts_pkg::data_t           over_budget_count,
	output fts_pkg::data_t           critical_over_budget_count,
	output fts_pkg::data_t           critical_mean_ms,
	output logic [fts_pkg::RankW-1:0] rank,
	output fts_pkg::data_t           top_value_ms,
	output logic                     last
);
	import fts_pkg::*;

	localparam int unsigned IdxW = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;
	localparam int unsigned CntW = $clog2(TOP_DEPTH + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_MEAN, S_DEV, S_CRIT, S_RIPPLE, S_OUT
	} state_t;

	state_t state_q;
	data_t budget_q;
	data_t count_q, mean_q, dev_q, max_q, over_q, crit_over_q, crit_mean_q;
	data_t smp_q, ccount_q;
	logic crit_q;
	logic [CntW-1:0] step_q;
	logic [CntW-1:0] fill_q;   // ranks taking part in the insertion
	logic [IdxW-1:0] rank_q;

	cell_ctrl_t ctrl;
	logic div_start, div_done;
	logic signed [32:0] div_num, div_q;
	data_t div_den;

	data_t carry [TOP_DEPTH+1];
	data_t vals [TOP_DEPTH];

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) budget_q <= '0;
		else if (cfg_valid) budget_q <= budget;
	end

	fts_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_num),
		.divisor(div_den), .done(div_done), .quotient(div_q)
	);

	// Carry enters rank 0 as the sample; it is registered in each cell.
	// Cell g compares only at ripple step g, when its left neighbor's carry is fresh.
	assign carry[0] = smp_q;
	for (genvar g = 0; g < TOP_DEPTH; g++) begin : g_cell
		fts_top_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctrl(ctrl),
			.active((CntW'(g) < fill_q) && (step_q == CntW'(g))),
			.carry_in(g == 0 ? smp_q : carry[g]),
			.carry_out(carry[g+1]),
			.rot_in(vals[(g + 1) % TOP_DEPTH]),
			.value(vals[g])
		);
	end

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign sample_count = count_q;
	assign mean_ms = mean_q;
	assign deviation_ms = dev_q;
	assign max_ms = max_q;
	assign over_budget_count = over_q;
	assign critical_over_budget_count = crit_over_q;
	assign critical_mean_ms = crit_mean_q;
	assign rank = RankW'(rank_q);
	assign top_value_ms = vals[0];
	assign last = (rank_q == IdxW'(TOP_DEPTH - 1));

	logic in_acc, over_hit;
	data_t absd, new_mean;
	assign in_acc = in_valid && !in_stall;
	assign over_hit = (budget_q != '0) && (smp_q > budget_q);
	assign new_mean = 32'($signed({1'b0, mean_q}) + div_q);
	assign absd = (smp_q >= new_mean) ? smp_q - new_mean : new_mean - smp_q;

	// Cell and divider control. Ripple: one rank per cycle, carry hops each cycle.
	always_comb begin
		ctrl = '0;
		ctrl.clear = in_acc && (operation == OpClear);
		ctrl.load = (state_q == S_RIPPLE);
		ctrl.shift = out_valid && !out_stall;
		div_start = 1'b0;
		div_num = '0;
		div_den = count_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc && operation == OpCollect && count_q != '0) begin
					div_start = 1'b1;
					div_num = $signed({1'b0, sample_ms}) - $signed({1'b0, mean_q});
					div_den = (count_q == '1) ? count_q : count_q + 32'd1;
				end
			end
			S_MEAN: begin
				if (div_done) begin
					div_start = 1'b1;
					div_num = $signed({1'b0, absd}) - $signed({1'b0, dev_q});
				end
			end
			S_DEV: begin
				if (div_done && over_hit && crit_q && ccount_q != '0) begin
					div_start = 1'b1;
					div_num = $signed({1'b0, smp_q}) - $signed({1'b0, crit_mean_q});
					div_den = ccount_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0; mean_q <= '0; dev_q <= '0; max_q <= '0;
			over_q <= '0; crit_over_q <= '0; crit_mean_q <= '0;
			step_q <= '0; fill_q <= '0; rank_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					rank_q <= '0;
					fill_q <= '0;
					if (in_acc) begin
						smp_q <= sample_ms;
						crit_q <= in_critical_frame;
						ccount_q <= critical_frame_count;
						if (operation == OpClear) begin
							count_q <= '0; mean_q <= '0; dev_q <= '0; max_q <= '0;
							over_q <= '0; crit_over_q <= '0; crit_mean_q <= '0;
							state_q <= S_OUT;
						end else if (count_q == '0) begin
							count_q <= 32'd1;
							mean_q <= sample_ms;
							dev_q <= '0;
							max_q <= '0;
							state_q <= S_OUT;
						end else begin
							if (count_q != '1) count_q <= count_q + 32'd1;
							state_q <= S_MEAN;
						end
					end
				end
				S_MEAN: if (div_done) begin
					mean_q <= new_mean;
					state_q <= S_DEV;
				end
				S_DEV: if (div_done) begin
					dev_q <= 32'($signed({1'b0, dev_q}) + div_q);
					if (smp_q > max_q) max_q <= smp_q;
					if (over_hit) begin
						if (over_q != '1) over_q <= over_q + 32'd1;
						if (crit_q && crit_over_q != '1) crit_over_q <= crit_over_q + 32'd1;
					end
					fill_q <= (count_q >= 32'(TOP_DEPTH)) ? CntW'(TOP_DEPTH)
						: CntW'(count_q);
					step_q <= '0;
					state_q <= (over_hit && crit_q && ccount_q != '0) ? S_CRIT : S_RIPPLE;
				end
				S_CRIT: if (div_done) begin
					crit_mean_q <= 32'($signed({1'b0, crit_mean_q}) + div_q);
					state_q <= S_RIPPLE;
				end
				S_RIPPLE: begin
					step_q <= step_q + CntW'(1);
					if (step_q == CntW'(TOP_DEPTH - 1)) state_q <= S_OUT;
				end
				S_OUT: if (!out_stall) begin
					rank_q <= rank_q + IdxW'(1);
					if (rank_q == IdxW'(TOP_DEPTH - 1)) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
